>>> design/atcp_pkg.sv
// ----------------------------------------------------------------------------
// Terminal cursor parser package
// Parser modes, result kinds, register indexes, byte codes and small helpers
// shared by the terminal cursor parser.
// ----------------------------------------------------------------------------
package atcp_pkg;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_CSI  = 2'd2
   } parser_mode_type;

   // Result kinds carried on the result channel's tuser.
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_COLUMNS     = 3'd0;
   localparam logic [2:0] REG_SCREEN_ROWS = 3'd1;
   localparam logic [2:0] REG_START_COL   = 3'd2;
   localparam logic [2:0] REG_START_ROW   = 3'd3;
   localparam logic [2:0] REG_CLEAR_SUPP  = 3'd4;

   localparam logic [7:0] RESET_COLUMNS = 8'd80;
   localparam logic [7:0] RESET_ROWS    = 8'd24;

   // Byte codes.
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_EIGHT  = 8'h38;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_PRIV_HI = 8'h3F;
   localparam logic [7:0] CH_FINAL_LO = 8'h40;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_FINAL_HI = 8'h7E;

   // CSI final bytes.
   localparam logic [7:0] CMD_UP      = 8'h41;  // A
   localparam logic [7:0] CMD_DOWN    = 8'h42;  // B
   localparam logic [7:0] CMD_FWD     = 8'h43;  // C
   localparam logic [7:0] CMD_BACK    = 8'h44;  // D
   localparam logic [7:0] CMD_NEXTLN  = 8'h45;  // E
   localparam logic [7:0] CMD_PREVLN  = 8'h46;  // F
   localparam logic [7:0] CMD_COLUMN  = 8'h47;  // G
   localparam logic [7:0] CMD_POS     = 8'h48;  // H
   localparam logic [7:0] CMD_ERASE_D = 8'h4A;  // J
   localparam logic [7:0] CMD_ERASE_L = 8'h4B;  // K
   localparam logic [7:0] CMD_POS_F   = 8'h66;  // f
   localparam logic [7:0] CMD_SAVE    = 8'h73;  // s
   localparam logic [7:0] CMD_RESTORE = 8'h75;  // u

   localparam logic [9:0] ARG_MAX = 10'd999;

   // Erase modes.
   localparam logic [9:0] ERASE_TO_END   = 10'd0;
   localparam logic [9:0] ERASE_TO_START = 10'd1;
   localparam logic [9:0] ERASE_ALL      = 10'd2;
   localparam logic [9:0] ERASE_SAVED    = 10'd3;

   // Clamp an 8-bit value below a nonzero limit.
   function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] lim);
      clamp8 = (v >= lim) ? lim - 8'd1 : v;
   endfunction

   // Clamp an 11-bit value below a nonzero 8-bit limit.
   function automatic logic [7:0] clamp11(input logic [10:0] v, input logic [7:0] lim);
      clamp11 = (v >= {3'd0, lim}) ? lim - 8'd1 : v[7:0];
   endfunction

endpackage

>>> design/ansi_terminal_cursor_parser.sv
// ----------------------------------------------------------------------------
// ANSI terminal cursor parser
// Parses a terminal byte stream (text, ESC and CSI sequences), tracks the
// cursor and a saved cursor, and reports cell writes, fill ranges and clears.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one item per terminal byte (tdata) with tuser
//   low, or a restart with tuser high. A restart puts the cursor at the
//   clamped start position and the parser back to text mode.
//   The rsp channel carries at most one result per item: a cell write, a
//   space fill over a row-major range, or a clear screen (kind in tuser).
//   The csr port writes the geometry and start registers one per cycle;
//   write them only while no item is in flight.
// Timing:
//   An accepted item is held in an input register and processed against
//   the parser and cursor registers once the result register is empty or
//   being drained; its result, if any, is registered and visible on rsp.
//   One item is taken per cycle as long as that condition holds.
//   When the receiver stalls, the result register holds and the input
//   register fills, after which req_tready drops until rsp is taken.
//   Reset clears the parser, cursor and saved cursor and loads the register
//   defaults (80 columns, 24 rows, start at the origin, clear enabled).
// ----------------------------------------------------------------------------
module ansi_terminal_cursor_parser #(
   parameter int MAX_ARGS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] req_type (1 = restart)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // first_col, first_row, last_col, last_row, cell_char
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import atcp_pkg::*;

   localparam int SLOT_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ARGS - 1);

   // Configuration registers.
   logic [7:0] columns_ff, rows_ff, start_col_ff, start_row_ff;
   logic       clear_supp_ff;

   // Input stage.
   logic       in_valid_ff, in_valid_in;
   logic       in_restart_ff;
   logic [7:0] in_byte_ff;

   // Parser and cursor state.
   parser_mode_type   mode_ff, mode_in;
   logic [9:0]        args_ff [MAX_ARGS];
   logic [9:0]        args_in [MAX_ARGS];
   logic              seen_ff [MAX_ARGS];
   logic              seen_in [MAX_ARGS];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [7:0]        col_ff, col_in, row_ff, row_in;
   logic [7:0]        saved_col_ff, saved_col_in, saved_row_ff, saved_row_in;
   logic              saved_valid_ff, saved_valid_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [39:0] rsp_data_ff;

   // Processing signals.
   logic        advance;
   logic [7:0]  cols, rows, cm1, rm1, b;
   logic [9:0]  n_arg, m_arg, mode_arg;
   logic [13:0] digit_prod;
   logic [10:0] col_plus, row_plus;
   logic [7:0]  col_minus, row_minus;
   logic [8:0]  tab_stop;
   logic        res_valid;
   logic [1:0]  res_kind;
   logic [7:0]  res_fc, res_fr, res_lc, res_lr, res_ch;
   logic        clear_args;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !advance);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff    <= RESET_COLUMNS;
         rows_ff       <= RESET_ROWS;
         start_col_ff  <= 8'd0;
         start_row_ff  <= 8'd0;
         clear_supp_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_COLUMNS:     columns_ff    <= csr_wdata;
            REG_SCREEN_ROWS: rows_ff       <= csr_wdata;
            REG_START_COL:   start_col_ff  <= csr_wdata;
            REG_START_ROW:   start_row_ff  <= csr_wdata;
            REG_CLEAR_SUPP:  clear_supp_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective geometry: a zero register acts as one.
   assign cols = (columns_ff == 8'd0) ? 8'd1 : columns_ff;
   assign rows = (rows_ff == 8'd0) ? 8'd1 : rows_ff;
   assign cm1  = cols - 8'd1;
   assign rm1  = rows - 8'd1;
   assign b    = in_byte_ff;

   // Count argument (zero or missing means one) and second argument likewise.
   assign n_arg    = (seen_ff[0] && args_ff[0] != 10'd0) ? args_ff[0] : 10'd1;
   assign m_arg    = (seen_ff[1] && args_ff[1] != 10'd0) ? args_ff[1] : 10'd1;
   assign mode_arg = seen_ff[0] ? args_ff[0] : 10'd0;

   assign digit_prod = {4'd0, args_ff[slot_ff]} * 14'd10 + {10'd0, b[3:0]};
   assign col_plus   = {3'd0, col_ff} + {1'b0, n_arg};
   assign row_plus   = {3'd0, row_ff} + {1'b0, n_arg};
   assign col_minus  = (n_arg >= {2'd0, col_ff}) ? 8'd0 : col_ff - n_arg[7:0];
   assign row_minus  = (n_arg >= {2'd0, row_ff}) ? 8'd0 : row_ff - n_arg[7:0];
   assign tab_stop   = ({1'b0, col_ff} + 9'd4) & ~9'd3;

   always_comb begin
      mode_in        = mode_ff;
      slot_in        = slot_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      saved_col_in   = saved_col_ff;
      saved_row_in   = saved_row_ff;
      saved_valid_in = saved_valid_ff;
      clear_args     = 1'b0;
      res_valid      = 1'b0;
      res_kind       = KIND_WRITE;
      res_fc         = 8'd0;
      res_fr         = 8'd0;
      res_lc         = 8'd0;
      res_lr         = 8'd0;
      res_ch         = 8'd0;
      for (int i = 0; i < MAX_ARGS; i++) begin
         args_in[i] = args_ff[i];
         seen_in[i] = seen_ff[i];
      end

      if (in_restart_ff) begin
         col_in     = clamp8(start_col_ff, cols);
         row_in     = clamp8(start_row_ff, rows);
         mode_in    = MODE_TEXT;
         clear_args = 1'b1;
      end else begin
         case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_TEXT;
               if (b == CH_LBRACKET) begin
                  clear_args = 1'b1;
                  mode_in    = MODE_CSI;
               end else if (b == CH_SEVEN) begin
                  saved_col_in   = col_ff;
                  saved_row_in   = row_ff;
                  saved_valid_in = 1'b1;
               end else if (b == CH_EIGHT && saved_valid_ff) begin
                  col_in = clamp8(saved_col_ff, cols);
                  row_in = clamp8(saved_row_ff, rows);
               end
            end
            MODE_CSI: begin
               if (b >= CH_ZERO && b <= CH_NINE) begin
                  args_in[slot_ff] = (digit_prod > 14'(ARG_MAX)) ? ARG_MAX : digit_prod[9:0];
                  seen_in[slot_ff] = 1'b1;
               end else if (b == CH_SEMI) begin
                  if (slot_ff != LAST_SLOT) begin
                     slot_in = slot_ff + SLOT_W'(1);
                  end
               end else if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
                  mode_in = MODE_TEXT;
                  case (b)
                     CMD_UP: begin
                        row_in = clamp8(row_minus, rows);
                        col_in = clamp8(col_ff, cols);
                     end
                     CMD_DOWN: begin
                        row_in = clamp11(row_plus, rows);
                        col_in = clamp8(col_ff, cols);
                     end
                     CMD_FWD: begin
                        col_in = clamp11(col_plus, cols);
                        row_in = clamp8(row_ff, rows);
                     end
                     CMD_BACK: begin
                        col_in = clamp8(col_minus, cols);
                        row_in = clamp8(row_ff, rows);
                     end
                     CMD_NEXTLN: begin
                        row_in = clamp11(row_plus, rows);
                        col_in = 8'd0;
                     end
                     CMD_PREVLN: begin
                        row_in = clamp8(row_minus, rows);
                        col_in = 8'd0;
                     end
                     CMD_COLUMN: begin
                        row_in = clamp8(row_ff, rows);
                        col_in = clamp11({1'b0, n_arg - 10'd1}, cols);
                     end
                     CMD_POS, CMD_POS_F: begin
                        row_in = clamp11({1'b0, n_arg - 10'd1}, rows);
                        col_in = clamp11({1'b0, m_arg - 10'd1}, cols);
                     end
                     CMD_ERASE_D: begin
                        if (mode_arg == ERASE_ALL || mode_arg == ERASE_SAVED) begin
                           res_valid = clear_supp_ff;
                           res_kind  = KIND_CLEAR;
                        end else if (mode_arg == ERASE_TO_END) begin
                           res_kind = KIND_FILL;
                           res_ch   = CH_SPACE;
                           res_lc   = cm1;
                           res_lr   = rm1;
                           if (row_ff < rows) begin
                              if (col_ff < cols) begin
                                 res_valid = 1'b1;
                                 res_fc    = col_ff;
                                 res_fr    = row_ff;
                              end else if (row_ff + 8'd1 < rows) begin
                                 // Cursor past the right edge: start on the next row.
                                 res_valid = 1'b1;
                                 res_fc    = 8'd0;
                                 res_fr    = row_ff + 8'd1;
                              end
                           end
                        end else if (mode_arg == ERASE_TO_START) begin
                           res_valid = 1'b1;
                           res_kind  = KIND_FILL;
                           res_ch    = CH_SPACE;
                           if (row_ff >= rows) begin
                              res_lc = cm1;
                              res_lr = rm1;
                           end else begin
                              res_lc = clamp8(col_ff, cols);
                              res_lr = row_ff;
                           end
                        end
                     end
                     CMD_ERASE_L: begin
                        res_kind = KIND_FILL;
                        res_ch   = CH_SPACE;
                        res_fr   = row_ff;
                        res_lr   = row_ff;
                        if (row_ff < rows) begin
                           if (mode_arg == ERASE_TO_END) begin
                              res_valid = (col_ff < cols);
                              res_fc    = col_ff;
                              res_lc    = cm1;
                           end else if (mode_arg == ERASE_TO_START) begin
                              res_valid = 1'b1;
                              res_lc    = clamp8(col_ff, cols);
                           end else if (mode_arg == ERASE_ALL) begin
                              res_valid = 1'b1;
                              res_lc    = cm1;
                           end
                        end
                     end
                     CMD_SAVE: begin
                        saved_col_in   = col_ff;
                        saved_row_in   = row_ff;
                        saved_valid_in = 1'b1;
                     end
                     CMD_RESTORE: begin
                        if (saved_valid_ff) begin
                           col_in = clamp8(saved_col_ff, cols);
                           row_in = clamp8(saved_row_ff, rows);
                        end
                     end
                     default: ;
                  endcase
               end else if (b < CH_SPACE || b > CH_PRIV_HI) begin
                  // Any byte outside the CSI alphabet aborts the sequence.
                  mode_in = MODE_TEXT;
               end
            end
            default: begin
               case (b)
                  CH_ESC: mode_in = MODE_ESC;
                  CH_CR:  col_in  = 8'd0;
                  CH_LF: begin
                     col_in = 8'd0;
                     if ({1'b0, row_ff} + 9'd1 < {1'b0, rows}) begin
                        row_in = row_ff + 8'd1;
                     end
                  end
                  CH_BS: begin
                     if (col_ff != 8'd0) begin
                        col_in = col_ff - 8'd1;
                     end
                  end
                  CH_TAB: begin
                     // The next stop saturates at the last column.
                     col_in = (tab_stop >= {1'b0, cols}) ? cm1 : tab_stop[7:0];
                  end
                  default: begin
                     res_valid = 1'b1;
                     res_kind  = KIND_WRITE;
                     res_fc    = col_ff;
                     res_fr    = row_ff;
                     res_lc    = col_ff;
                     res_lr    = row_ff;
                     res_ch    = b;
                     if ({1'b0, col_ff} + 9'd1 < {1'b0, cols}) begin
                        col_in = col_ff + 8'd1;
                     end else begin
                        col_in = 8'd0;
                        if ({1'b0, row_ff} + 9'd1 < {1'b0, rows}) begin
                           row_in = row_ff + 8'd1;
                        end
                     end
                  end
               endcase
            end
         endcase
      end

      if (clear_args) begin
         slot_in = '0;
         for (int i = 0; i < MAX_ARGS; i++) begin
            args_in[i] = 10'd0;
            seen_in[i] = 1'b0;
         end
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_TEXT;
         slot_ff        <= '0;
         col_ff         <= 8'd0;
         row_ff         <= 8'd0;
         saved_col_ff   <= 8'd0;
         saved_row_ff   <= 8'd0;
         saved_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ARGS; i++) begin
            args_ff[i] <= 10'd0;
            seen_ff[i] <= 1'b0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff        <= mode_in;
            slot_ff        <= slot_in;
            col_ff         <= col_in;
            row_ff         <= row_in;
            saved_col_ff   <= saved_col_in;
            saved_row_ff   <= saved_row_in;
            saved_valid_ff <= saved_valid_in;
            for (int i = 0; i < MAX_ARGS; i++) begin
               args_ff[i] <= args_in[i];
               seen_ff[i] <= seen_in[i];
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_restart_ff <= req_tuser;
         in_byte_ff    <= req_tdata;
      end
      if (advance && res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_data_ff <= {res_ch, res_lr, res_lc, res_fr, res_fc};
      end
   end

`ifndef ASSERT_OFF
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_CLEAR) |-> (rsp_data_ff == 40'd0))
      else $error("clear screen result carries nonzero fields");

   a_write_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_WRITE) |->
      (rsp_data_ff[7:0] == rsp_data_ff[23:16] && rsp_data_ff[15:8] == rsp_data_ff[31:24]))
      else $error("cell write range covers more than one cell");

   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_FILL) |->
      (rsp_data_ff[15:8] <= rsp_data_ff[31:24] && rsp_data_ff[39:32] == CH_SPACE))
      else $error("fill range out of row order or not filled with spaces");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff != 2'd3))
      else $error("result kind out of range");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, slot_ff} <= {1'b0, LAST_SLOT})
      else $error("argument slot beyond last slot");
`endif

endmodule
